// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define DCSA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled in reset
`define DCSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/dcsa_pkg.sv =====
// types, codes and helper functions of the sector addresser
// no dependencies
package dcsa_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      FUNC_LOAD    = 2'd0,
      FUNC_ADVANCE = 2'd1,
      FUNC_SEEK    = 2'd2,
      FUNC_RECAL   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_ILLEGAL  = 2'd1,
      ERR_SEEKFAIL = 2'd2,
      ERR_NOTREADY = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      REG_D0_CFG_HEADS = 3'd0,
      REG_D0_CFG_CYLS  = 3'd1,
      REG_D0_PHYS_HEADS = 3'd2,
      REG_D1_CFG_HEADS = 3'd3,
      REG_D1_CFG_CYLS  = 3'd4,
      REG_D1_PHYS_HEADS = 3'd5,
      REG_PRESENT      = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [1:0][4:0]  cfg_heads;
      logic [1:0][10:0] cfg_cyls;
      logic [1:0][4:0]  phys_heads;
      logic [1:0]       present;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic calc;
      logic done;
   } cmd_type;

   // highest legal cylinder for a configured count
   function automatic logic [9:0] cyl_limit(input logic [10:0] cyls);
      logic [10:0] lim;
      lim = (cyls == 11'd0) ? 11'd0 : cyls - 11'd1;
      return (lim > 11'd1023) ? 10'd1023 : lim[9:0];
   endfunction

   function automatic logic [9:0] clamp_cyl(input logic [9:0] lim, input logic [10:0] c);
      return (c > {1'b0, lim}) ? lim : c[9:0];
   endfunction

endpackage

// ===== rtl/dcsa_req_if.sv =====
// command channel of the sector addresser
// no dependencies
interface dcsa_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic       drive_select;
   logic [9:0] cylinder;
   logic [4:0] head_number;
   logic [5:0] sector_number;

   modport source (
      output valid, func, drive_select, cylinder, head_number, sector_number,
      input  ready
   );
   modport sink (
      input  valid, func, drive_select, cylinder, head_number, sector_number,
      output ready
   );
endinterface

// ===== rtl/dcsa_rsp_if.sv =====
// result channel of the sector addresser
// no dependencies
interface dcsa_rsp_if;
   logic        valid;
   logic        ready;
   logic        error_flag;
   logic [1:0]  error_code;
   logic [19:0] lba;
   logic [9:0]  current_cylinder;
   logic        drive_bit;

   modport source (
      output valid, error_flag, error_code, lba, current_cylinder, drive_bit,
      input  ready
   );
   modport sink (
      input  valid, error_flag, error_code, lba, current_cylinder, drive_bit,
      output ready
   );
endinterface

// ===== rtl/disk_chs_sector_addresser.sv =====
// Sector-position engine of a two-drive controller. Each command item (load
// position, advance one sector, seek, recalibrate) updates the held position at
// the edge it is accepted, then passes the calc state (address check and
// cylinder*heads+head) and the done state (multiply by sectors per track into
// the linear address in the result register), which waits while a held result
// is not yet taken. A new item is taken only in idle, after the last has left
// done; the result register lets the next item enter while a result waits.
// Geometry and drive presence come from the csr port (word registers at 4*i).
// top level; depends on dcsa_pkg, dcsa_req_if, dcsa_rsp_if, dcsa_csr,
// dcsa_ctrl, dcsa_datapath and assert_macros.svh
`include "assert_macros.svh"

module disk_chs_sector_addresser #(
   parameter int SECTORS_PER_TRACK = 17,
   parameter int DRIVE_COUNT       = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   dcsa_req_if.sink                         req_if,
   dcsa_rsp_if.source                       rsp_if,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dcsa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dcsa_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dcsa_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   dcsa_pkg::cfg_type cfg;
   dcsa_pkg::cmd_type cmd;

   dcsa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   dcsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   dcsa_datapath #(
      .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
      .DRIVE_COUNT       (DRIVE_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cfg              (cfg),
      .func             (req_if.func),
      .drive_select     (req_if.drive_select),
      .cylinder         (req_if.cylinder),
      .head_number      (req_if.head_number),
      .sector_number    (req_if.sector_number),
      .error_flag       (rsp_if.error_flag),
      .error_code       (rsp_if.error_code),
      .lba              (rsp_if.lba),
      .current_cylinder (rsp_if.current_cylinder),
      .drive_bit        (rsp_if.drive_bit)
   );

   `DCSA_ASSERT_NEXT(a_accept_then_calc, clock, reset, req_if.valid && req_if.ready, cmd.calc && !req_if.ready)
   `DCSA_ASSERT_NOW(a_flag_matches_code, clock, reset, rsp_if.valid, rsp_if.error_flag == (rsp_if.error_code != dcsa_pkg::ERR_NONE))
   `DCSA_ASSERT_NOW(a_error_zero_lba, clock, reset, rsp_if.valid && rsp_if.error_flag, rsp_if.lba == 20'd0)
   `DCSA_ASSERT_NEXT(a_done_sets_valid, clock, reset, cmd.done, rsp_if.valid)

endmodule

// ===== rtl/dcsa_csr.sv =====
// geometry and presence registers behind the apb-style port
// depends on dcsa_pkg
module dcsa_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [dcsa_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [dcsa_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [dcsa_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output dcsa_pkg::cfg_type                cfg
);

   dcsa_pkg::cfg_type       cfg_ff, cfg_in;
   dcsa_pkg::reg_index_type idx;
   logic                    wr_en;
   logic [10:0]             wval;

   assign idx    = dcsa_pkg::reg_index_type'(paddr[4:2]);
   assign wr_en  = psel & penable & pwrite;
   assign wval   = pwdata[10:0];
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            dcsa_pkg::REG_D0_CFG_HEADS:  cfg_in.cfg_heads[0]  = wval[4:0];
            dcsa_pkg::REG_D0_CFG_CYLS:   cfg_in.cfg_cyls[0]   = wval;
            dcsa_pkg::REG_D0_PHYS_HEADS: cfg_in.phys_heads[0] = wval[4:0];
            dcsa_pkg::REG_D1_CFG_HEADS:  cfg_in.cfg_heads[1]  = wval[4:0];
            dcsa_pkg::REG_D1_CFG_CYLS:   cfg_in.cfg_cyls[1]   = wval;
            dcsa_pkg::REG_D1_PHYS_HEADS: cfg_in.phys_heads[1] = wval[4:0];
            dcsa_pkg::REG_PRESENT:       cfg_in.present       = wval[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         dcsa_pkg::REG_D0_CFG_HEADS:  prdata = 32'(cfg_ff.cfg_heads[0]);
         dcsa_pkg::REG_D0_CFG_CYLS:   prdata = 32'(cfg_ff.cfg_cyls[0]);
         dcsa_pkg::REG_D0_PHYS_HEADS: prdata = 32'(cfg_ff.phys_heads[0]);
         dcsa_pkg::REG_D1_CFG_HEADS:  prdata = 32'(cfg_ff.cfg_heads[1]);
         dcsa_pkg::REG_D1_CFG_CYLS:   prdata = 32'(cfg_ff.cfg_cyls[1]);
         dcsa_pkg::REG_D1_PHYS_HEADS: prdata = 32'(cfg_ff.phys_heads[1]);
         dcsa_pkg::REG_PRESENT:       prdata = 32'(cfg_ff.present);
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cfg_heads  <= {5'd4, 5'd4};
         cfg_ff.cfg_cyls   <= {11'd615, 11'd615};
         cfg_ff.phys_heads <= {5'd4, 5'd4};
         cfg_ff.present    <= 2'b00;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/dcsa_ctrl.sv =====
// sequencing state machine and result valid of the sector addresser
// depends on dcsa_pkg
module dcsa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dcsa_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign cmd.load  = req_valid & req_ready;
   assign cmd.calc  = (state_ff == ST_CALC);
   assign cmd.done  = (state_ff == ST_DONE) & (~rsp_valid_ff | rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) state_in = ST_CALC;
         end
         ST_CALC: state_in = ST_DONE;
         ST_DONE: begin
            if (cmd.done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (cmd.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/dcsa_datapath.sv =====
// position state, address check and linear address arithmetic
// depends on dcsa_pkg
module dcsa_datapath #(
   parameter int SECTORS_PER_TRACK = 17,
   parameter int DRIVE_COUNT       = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  dcsa_pkg::cmd_type cmd,
   input  dcsa_pkg::cfg_type cfg,
   input  logic [1:0]        func,
   input  logic              drive_select,
   input  logic [9:0]        cylinder,
   input  logic [4:0]        head_number,
   input  logic [5:0]        sector_number,
   output logic              error_flag,
   output logic [1:0]        error_code,
   output logic [19:0]       lba,
   output logic [9:0]        current_cylinder,
   output logic              drive_bit
);

   localparam logic [6:0] SPT = 7'(SECTORS_PER_TRACK);

   logic            sel_ff, sel_in;
   logic [9:0]      req_cyl_ff, req_cyl_in;
   logic [4:0]      req_head_ff, req_head_in;
   logic [5:0]      req_sector_ff, req_sector_in;
   logic [1:0][9:0] dcyl_ff, dcyl_in;
   logic [1:0]      pre_err_ff, pre_err_in;
   logic            addr_chk_ff, addr_chk_in;
   logic [1:0]      err_ff;
   logic [15:0]     prod_ff;

   logic [1:0]      err_in;
   logic [15:0]     prod_in;
   logic            eff_drive, d_in, present, illegal;
   logic [9:0]      lim_in, clamped_in;
   logic [6:0]      s_next;
   logic [5:0]      h_next;
   logic [22:0]     full_lba;

   logic            error_flag_ff;
   logic [1:0]      error_code_ff;
   logic [19:0]     lba_ff;
   logic [9:0]      cur_cyl_ff;
   logic            drive_bit_ff;

   assign eff_drive  = (32'(drive_select) >= DRIVE_COUNT) ? 1'(DRIVE_COUNT - 1) : drive_select;
   assign d_in       = (func == dcsa_pkg::FUNC_ADVANCE) ? sel_ff : eff_drive;
   assign present    = cfg.present[d_in];
   assign lim_in     = dcsa_pkg::cyl_limit(cfg.cfg_cyls[d_in]);
   assign clamped_in = dcsa_pkg::clamp_cyl(lim_in, {1'b0, cylinder});

   // position update at item acceptance
   always_comb begin
      sel_in        = sel_ff;
      req_cyl_in    = req_cyl_ff;
      req_head_in   = req_head_ff;
      req_sector_in = req_sector_ff;
      dcyl_in       = dcyl_ff;
      pre_err_in    = pre_err_ff;
      addr_chk_in   = addr_chk_ff;
      s_next        = {1'b0, req_sector_ff} + 7'd1;
      h_next        = {1'b0, req_head_ff} + 6'd1;
      if (cmd.load) begin
         sel_in      = d_in;
         pre_err_in  = dcsa_pkg::ERR_NONE;
         addr_chk_in = (func == dcsa_pkg::FUNC_LOAD) || (func == dcsa_pkg::FUNC_ADVANCE);
         unique case (dcsa_pkg::func_type'(func))
            dcsa_pkg::FUNC_LOAD: begin
               req_cyl_in    = cylinder;
               req_head_in   = head_number;
               req_sector_in = sector_number;
               dcyl_in[d_in] = clamped_in;
            end
            dcsa_pkg::FUNC_ADVANCE: begin
               if (s_next >= SPT) begin
                  s_next = '0;
                  if (h_next >= {1'b0, cfg.cfg_heads[d_in]}) begin
                     h_next        = '0;
                     req_cyl_in    = req_cyl_ff + 10'd1;
                     dcyl_in[d_in] = dcsa_pkg::clamp_cyl(lim_in,
                                        {1'b0, dcyl_ff[d_in]} + 11'd1);
                  end
                  req_head_in = h_next[4:0];
               end
               req_sector_in = s_next[5:0];
            end
            dcsa_pkg::FUNC_SEEK: begin
               if (!present) begin
                  pre_err_in = dcsa_pkg::ERR_NOTREADY;
               end else begin
                  dcyl_in[d_in] = clamped_in;
                  if (clamped_in != cylinder) pre_err_in = dcsa_pkg::ERR_SEEKFAIL;
               end
            end
            dcsa_pkg::FUNC_RECAL: begin
               if (!present) begin
                  pre_err_in = dcsa_pkg::ERR_NOTREADY;
               end else begin
                  req_cyl_in    = '0;
                  dcyl_in[d_in] = '0;
               end
            end
            default: ;
         endcase
      end
   end

   // address check and first product
   assign illegal = (dcyl_ff[sel_ff] != req_cyl_ff)
                 || (req_head_ff >= cfg.cfg_heads[sel_ff])
                 || (req_head_ff >= cfg.phys_heads[sel_ff])
                 || ({1'b0, req_sector_ff} >= SPT);
   assign err_in  = addr_chk_ff ? (illegal ? dcsa_pkg::ERR_ILLEGAL : dcsa_pkg::ERR_NONE)
                                : pre_err_ff;
   assign prod_in = 16'(req_cyl_ff) * 16'(cfg.cfg_heads[sel_ff]) + 16'(req_head_ff);

   // second product into the result register
   assign full_lba = 23'(prod_ff) * 23'(SPT) + 23'(req_sector_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff        <= 1'b0;
         req_cyl_ff    <= '0;
         req_head_ff   <= '0;
         req_sector_ff <= '0;
         dcyl_ff       <= '0;
         pre_err_ff    <= dcsa_pkg::ERR_NONE;
         addr_chk_ff   <= 1'b0;
      end else begin
         sel_ff        <= sel_in;
         req_cyl_ff    <= req_cyl_in;
         req_head_ff   <= req_head_in;
         req_sector_ff <= req_sector_in;
         dcyl_ff       <= dcyl_in;
         pre_err_ff    <= pre_err_in;
         addr_chk_ff   <= addr_chk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         err_ff  <= err_in;
         prod_ff <= prod_in;
      end
      if (cmd.done) begin
         error_flag_ff <= (err_ff != dcsa_pkg::ERR_NONE);
         error_code_ff <= err_ff;
         lba_ff        <= (addr_chk_ff && err_ff == dcsa_pkg::ERR_NONE) ? full_lba[19:0] : '0;
         cur_cyl_ff    <= dcyl_ff[sel_ff];
         drive_bit_ff  <= sel_ff;
      end
   end

   assign error_flag       = error_flag_ff;
   assign error_code       = error_code_ff;
   assign lba              = lba_ff;
   assign current_cylinder = cur_cyl_ff;
   assign drive_bit        = drive_bit_ff;

endmodule
